>>> rtl/core/hash_table_insert_lookup_defines.svh
// ----------------------------------------------------------------------------
// Hash table assertion macros
// Shared assertion helpers for the hash table block; empty when ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef HASH_TABLE_INSERT_LOOKUP_DEFINES_SVH
`define HASH_TABLE_INSERT_LOOKUP_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define HTI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hti assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define HTI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hti assertion failed");
`else
`define HTI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HTI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/hti_pkg.sv
// ----------------------------------------------------------------------------
// Hash table package
// Field widths, operation and status codes, and controller states.
// ----------------------------------------------------------------------------
package hti_pkg;

    localparam int KEY_W        = 31;
    localparam int OUT_HANDLE_W = 16;
    localparam int STATUS_W     = 3;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_EVAL
    } t_state;

endpackage

>>> rtl/core/hti_req_if.sv
// ----------------------------------------------------------------------------
// Hash table request channel
// Valid/ready channel carrying one lookup or insert transaction.
// ----------------------------------------------------------------------------
interface hti_req_if;
    import hti_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [KEY_W-1:0]        key;
    logic [OUT_HANDLE_W-1:0] record_handle;

    modport source (output valid, output operation, output key, output record_handle,
                    input ready);
    modport sink (input valid, input operation, input key, input record_handle,
                  output ready);
endinterface

>>> rtl/core/hti_rsp_if.sv
// ----------------------------------------------------------------------------
// Hash table response channel
// Valid/ready channel carrying the status and handle of one transaction.
// ----------------------------------------------------------------------------
interface hti_rsp_if;
    import hti_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [OUT_HANDLE_W-1:0] found_handle;

    modport source (output valid, output status, output found_handle, input ready);
    modport sink (input valid, input status, input found_handle, output ready);
endinterface

>>> rtl/core/hti_mod.sv
// ----------------------------------------------------------------------------
// Hash table bucket remainder unit
// Computes key modulo BUCKETS by reciprocal multiplication, one step per cycle.
// ----------------------------------------------------------------------------
module hti_mod #(
    parameter int BUCKETS = 1021
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  logic [hti_pkg::KEY_W-1:0]                    i_key,
    output logic                                         o_done,
    output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] o_rem
);
    import hti_pkg::*;

    localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int DW     = $clog2(BUCKETS + 1);
    localparam int SHIFT  = KEY_W + BW;
    localparam int MAG_W  = KEY_W + 2;
    localparam int LO_W   = 16;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int PROD_W = KEY_W + MAG_W;

    // The reciprocal is rounded up with KEY_W + BW fraction bits, which keeps
    // the quotient exact for every key of KEY_W bits.
    localparam logic [63:0]     MAGIC    = ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1)
                                           / 64'(BUCKETS);
    localparam logic [LO_W-1:0] MAGIC_LO = MAGIC[LO_W-1:0];
    localparam logic [HI_W-1:0] MAGIC_HI = MAGIC[MAG_W-1:LO_W];
    localparam logic [DW-1:0]   DIVISOR  = DW'(BUCKETS);

    logic [2:0]            r_vld;
    logic                  r_done;
    logic [KEY_W-1:0]      r_key;
    logic [KEY_W+LO_W-1:0] r_prod_lo;
    logic [KEY_W+HI_W-1:0] r_prod_hi;
    logic [KEY_W-1:0]      r_quot;
    logic [KEY_W-1:0]      r_back;
    logic [BW-1:0]         r_rem;

    logic [PROD_W-1:0]     full_prod;
    logic [PROD_W-1:0]     quot_wide;
    logic [KEY_W+DW-1:0]   back_wide;
    logic [KEY_W-1:0]      diff;

    assign full_prod = {r_prod_hi, LO_W'(0)} + PROD_W'(r_prod_lo);
    assign quot_wide = full_prod >> SHIFT;
    assign back_wide = (KEY_W+DW)'(r_quot) * (KEY_W+DW)'(DIVISOR);
    assign diff      = r_key - r_back;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[1:0], i_start};
            r_done <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key     <= i_key;
            r_prod_lo <= (KEY_W+LO_W)'(i_key) * (KEY_W+LO_W)'(MAGIC_LO);
            r_prod_hi <= (KEY_W+HI_W)'(i_key) * (KEY_W+HI_W)'(MAGIC_HI);
        end
        if (r_vld[0]) begin
            r_quot <= quot_wide[KEY_W-1:0];
        end
        if (r_vld[1]) begin
            r_back <= back_wide[KEY_W-1:0];
        end
        if (r_vld[2]) begin
            r_rem <= diff[BW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/core/hash_table_insert_lookup.sv
// ----------------------------------------------------------------------------
// Hash table with insert and lookup
// Bucketed key-to-handle table held in one synchronous row memory.
// ----------------------------------------------------------------------------
// Each request transaction looks up or inserts a 31-bit key; each produces one
// response transaction with a status and, for a hit on lookup, the stored
// handle. The bucket is key modulo BUCKETS and holds WAYS slots in one memory
// row. Before the next request can be accepted, each request passes these
// steps: at acceptance the remainder unit forms the partial products of the
// key with a reciprocal of BUCKETS; registered steps then add them into the
// quotient, multiply the quotient back by BUCKETS and subtract to give the
// bucket index; the row is read from the bucket memory into a register; and
// the compare step checks all ways, writes the row back on an insert into a
// free way and loads the response register. A response that is not yet
// taken does not hold off acceptance of the next request, but that request
// then waits in the compare step until the response is taken. After reset,
// a clearing pass writes every bucket row once, while no request is accepted.
module hash_table_insert_lookup #(
    parameter int BUCKETS      = 1021,
    parameter int WAYS         = 4,
    parameter int HANDLE_WIDTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hti_req_if.sink   i_req,
    hti_rsp_if.source o_rsp
);
    import hti_pkg::*;

`include "hash_table_insert_lookup_defines.svh"

    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int EXT_W = (HANDLE_WIDTH > OUT_HANDLE_W) ? HANDLE_WIDTH : OUT_HANDLE_W;

    typedef struct packed {
        logic                    valid;
        logic [KEY_W-1:0]        key;
        logic [HANDLE_WIDTH-1:0] handle;
    } t_slot;

    typedef t_slot [WAYS-1:0] t_row;

    t_row r_mem [BUCKETS];

    t_state                  r_state;
    t_state                  n_state;
    t_op                     r_op;
    logic [KEY_W-1:0]        r_key;
    logic [HANDLE_WIDTH-1:0] r_handle;
    logic [BW-1:0]           r_bucket;
    logic [BW-1:0]           r_clr_addr;
    t_row                    r_rd_row;
    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [OUT_HANDLE_W-1:0] r_out_handle;

    logic                    req_ready;
    logic                    mod_start;
    logic                    mod_done;
    logic [BW-1:0]           mod_rem;
    logic                    rd_en;
    logic                    mem_we;
    logic [BW-1:0]           mem_waddr;
    t_row                    mem_wdata;
    logic                    out_load;
    logic                    hit_any;
    logic [WW-1:0]           hit_way;
    logic                    free_any;
    logic [WW-1:0]           free_way;
    t_row                    wr_row;
    t_status                 eval_status;
    logic [OUT_HANDLE_W-1:0] eval_handle;
    logic [EXT_W-1:0]        hit_handle_ext;
    logic [EXT_W-1:0]        in_handle_ext;

    hti_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (i_req.key),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // Ways are scanned from the top down so the lowest matching or free way wins.
    always_comb begin
        hit_any  = 1'b0;
        hit_way  = '0;
        free_any = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (r_rd_row[w].valid && (r_rd_row[w].key == r_key)) begin
                hit_any = 1'b1;
                hit_way = WW'(w);
            end
            if (!r_rd_row[w].valid) begin
                free_any = 1'b1;
                free_way = WW'(w);
            end
        end
    end

    always_comb begin
        hit_handle_ext = EXT_W'(r_rd_row[hit_way].handle);
        wr_row         = r_rd_row;
        wr_row[free_way].valid  = 1'b1;
        wr_row[free_way].key    = r_key;
        wr_row[free_way].handle = r_handle;
        eval_handle    = '0;
        unique case (r_op)
            OP_LOOKUP: begin
                if (hit_any) begin
                    eval_status = ST_FOUND;
                    eval_handle = hit_handle_ext[OUT_HANDLE_W-1:0];
                end else begin
                    eval_status = ST_NOT_FOUND;
                end
            end
            OP_INSERT: begin
                if (hit_any) begin
                    eval_status = ST_DUPLICATE;
                end else if (free_any) begin
                    eval_status = ST_INSERTED;
                end else begin
                    eval_status = ST_FULL;
                end
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        req_ready = 1'b0;
        mod_start = 1'b0;
        rd_en     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_bucket;
        mem_wdata = wr_row;
        out_load  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == BW'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                req_ready = 1'b1;
                if (i_req.valid) begin
                    mod_start = 1'b1;
                    n_state   = S_HASH;
                end
            end
            S_HASH: begin
                if (mod_done) begin
                    rd_en   = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    mem_we   = (eval_status == ST_INSERTED);
                    n_state  = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + BW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign in_handle_ext = EXT_W'(i_req.record_handle);

    always_ff @(posedge i_clk) begin
        if (mod_start) begin
            r_op     <= t_op'(i_req.operation);
            r_key    <= i_req.key;
            r_handle <= in_handle_ext[HANDLE_WIDTH-1:0];
        end
        if (mod_done) begin
            r_bucket <= mod_rem;
        end
        if (out_load) begin
            r_out_status <= eval_status;
            r_out_handle <= eval_handle;
        end
    end

    // Bucket row memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_row <= r_mem[mod_rem];
        end
    end

    assign i_req.ready        = req_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.found_handle = r_out_handle;

    `HTI_ASSERT_IMP(a_done_in_hash, i_clk, i_rst_n, mod_done, r_state == S_HASH)
    `HTI_ASSERT_IMP(a_rem_in_range, i_clk, i_rst_n, mod_done, (BW+1)'(mod_rem) < (BW+1)'(BUCKETS))
    `HTI_ASSERT_IMP(a_write_is_insert, i_clk, i_rst_n, (r_state == S_EVAL) && mem_we, r_op == OP_INSERT)
    `HTI_ASSERT_IMP(a_zero_handle, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status != ST_FOUND), o_rsp.found_handle == '0)
    `HTI_ASSERT_NXT(a_eval_to_idle, i_clk, i_rst_n, out_load, (r_state == S_IDLE) && r_out_valid)

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Hash table insert and lookup testbench
// Sends lookup and insert transactions into the hash table and checks every
// response against a bucket-by-bucket shadow of the table that is kept here.
// Directed items cover the key and handle extremes and the empty, duplicate
// and full bucket cases. Random items follow, aimed at a few crowded buckets.
// Both channels idle at random, and the response side holds off once for a
// long stretch so that the block fills up.
// ----------------------------------------------------------------------------
module testbench;
    import hti_pkg::*;

    localparam int BUCKETS      = 1021;
    localparam int WAYS         = 4;
    localparam int HANDLE_WIDTH = 16;
    localparam int SLOTS        = BUCKETS * WAYS;
    localparam int unsigned KEY_MAX = 32'h7FFF_FFFF;
    localparam int RANDOM_ITEMS = 1300;
    localparam int HOT_COUNT    = 16;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        t_op                     op;
        logic [KEY_W-1:0]        key;
        logic [OUT_HANDLE_W-1:0] handle;
    } t_request;

    typedef struct packed {
        t_status                 status;
        logic [OUT_HANDLE_W-1:0] handle;
    } t_reply;

    logic i_clk;
    logic i_rst_n;

    hti_req_if req_ch ();
    hti_rsp_if rsp_ch ();

    hash_table_insert_lookup #(
        .BUCKETS      (BUCKETS),
        .WAYS         (WAYS),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Shadow of the table, indexed by bucket * WAYS + way.
    bit [KEY_W-1:0]        shadow_key    [SLOTS];
    bit [OUT_HANDLE_W-1:0] shadow_handle [SLOTS];
    bit                    shadow_used   [SLOTS];

    t_request pending_requests[$];
    t_reply   expected_replies[$];
    t_request current_req;

    logic [KEY_W-1:0] inserted_keys[$];
    int unsigned      hot_buckets[HOT_COUNT];

    int total_items;
    int accepted_count;
    int reply_count;
    int error_count;
    int cycle_count;
    int send_gap;
    int recv_stall;
    logic hold_off;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.operation     = OP_LOOKUP;
        req_ch.key           = '0;
        req_ch.record_handle = '0;
        rsp_ch.ready         = 1'b0;
        hold_off             = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at reply %0d: %s", reply_count, what);
        error_count++;
    endtask

    // Works out the reply to one transaction and applies it to the shadow table.
    function automatic t_reply apply_to_table(input t_request r);
        int unsigned base;
        int          hit;
        t_reply      rep;
        base = (int'(r.key) % BUCKETS) * WAYS;
        hit  = -1;
        rep.handle = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (hit < 0 && shadow_used[base + w] && shadow_key[base + w] == r.key) begin
                hit = w;
            end
        end
        if (r.op == OP_LOOKUP) begin
            if (hit >= 0) begin
                rep.status = ST_FOUND;
                rep.handle = shadow_handle[base + hit];
            end else begin
                rep.status = ST_NOT_FOUND;
            end
        end else if (hit >= 0) begin
            rep.status = ST_DUPLICATE;
        end else begin
            rep.status = ST_FULL;
            for (int w = 0; w < WAYS; w++) begin
                if (rep.status == ST_FULL && !shadow_used[base + w]) begin
                    shadow_key[base + w]    = r.key;
                    shadow_handle[base + w] = r.handle;
                    shadow_used[base + w]   = 1'b1;
                    rep.status = ST_INSERTED;
                end
            end
        end
        return rep;
    endfunction

    function automatic logic [KEY_W-1:0] key_in_bucket(input int unsigned bucket);
        int unsigned max_mult;
        max_mult = (KEY_MAX - bucket) / BUCKETS;
        return KEY_W'(bucket + $urandom_range(0, max_mult) * BUCKETS);
    endfunction

    function automatic void add_request(input t_op op, input logic [KEY_W-1:0] key,
                                        input logic [OUT_HANDLE_W-1:0] handle);
        t_request r;
        r.op     = op;
        r.key    = key;
        r.handle = handle;
        pending_requests.push_back(r);
        if (op == OP_INSERT) begin
            inserted_keys.push_back(key);
        end
    endfunction

    // Mostly short gaps, a few long ones, and whole stretches with none.
    function automatic int pick_gap(input int phase);
        int r;
        r = $urandom_range(0, 99);
        if ((phase % 400) < 100) return 0;
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    // Driver: offers the pending requests and records each accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_replies.push_back(apply_to_table(current_req));
                accepted_count++;
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    current_req = pending_requests.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.operation     <= current_req.op;
                    req_ch.key           <= current_req.key;
                    req_ch.record_handle <= current_req.handle;
                    send_gap = pick_gap(accepted_count);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each response transaction and throttles the ready line.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch($sformatf("unexpected response, status %0d",
                                              rsp_ch.status));
                end else begin
                    t_reply exp_rep;
                    exp_rep = expected_replies.pop_front();
                    if (rsp_ch.status !== exp_rep.status)
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  rsp_ch.status, exp_rep.status.name()));
                    if (rsp_ch.found_handle !== exp_rep.handle)
                        report_mismatch($sformatf("handle %h, expected %h",
                                                  rsp_ch.found_handle, exp_rep.handle));
                end
                reply_count++;
            end
            if (hold_off) begin
                rsp_ch.ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                if ((cycle_count % 5000) >= 1500) begin
                    recv_stall = pick_gap(1000);
                end
            end
        end
    end

    // Long hold-off on the response side while requests keep coming.
    initial begin
        while (accepted_count < 300) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (600) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d requests accepted",
                     cycle_count, accepted_count, total_items);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned top_bucket;
        int          pick;
        logic [KEY_W-1:0] k;

        accepted_count = 0;
        reply_count    = 0;
        error_count    = 0;
        cycle_count    = 0;
        top_bucket     = KEY_MAX % BUCKETS;

        // Empty table, then the key and handle extremes.
        add_request(OP_LOOKUP, '0, 16'hFFFF);
        add_request(OP_INSERT, '0, 16'hFFFF);
        add_request(OP_LOOKUP, '0, 16'h0000);
        add_request(OP_INSERT, '0, 16'h1234);
        add_request(OP_INSERT, KEY_W'(KEY_MAX), 16'h0000);
        add_request(OP_LOOKUP, KEY_W'(KEY_MAX), 16'hFFFF);
        // Fill the bucket of the largest key, then overflow it.
        add_request(OP_INSERT, KEY_W'(top_bucket), 16'hAAAA);
        add_request(OP_INSERT, KEY_W'(top_bucket + BUCKETS), 16'h5555);
        add_request(OP_INSERT, KEY_W'(top_bucket + 2 * BUCKETS), 16'h8001);
        add_request(OP_INSERT, KEY_W'(top_bucket + 3 * BUCKETS), 16'h7FFE);
        // A key already present reports duplicate even in a full bucket.
        add_request(OP_INSERT, KEY_W'(KEY_MAX), 16'h0F0F);
        add_request(OP_INSERT, KEY_W'(top_bucket + 2 * BUCKETS), 16'h0F0F);
        add_request(OP_LOOKUP, KEY_W'(top_bucket + 3 * BUCKETS), 16'h0000);
        add_request(OP_LOOKUP, KEY_W'(top_bucket + 4 * BUCKETS), 16'h0000);
        add_request(OP_LOOKUP, KEY_W'(top_bucket), 16'h0000);
        add_request(OP_LOOKUP, KEY_W'(top_bucket + BUCKETS), 16'h0000);
        add_request(OP_LOOKUP, KEY_W'(top_bucket + 2 * BUCKETS), 16'h0000);
        // Same bucket as key zero but a different key.
        add_request(OP_LOOKUP, KEY_W'(BUCKETS), 16'h0000);
        add_request(OP_INSERT, KEY_W'(BUCKETS), 16'h0001);
        add_request(OP_LOOKUP, KEY_W'(BUCKETS), 16'h0000);

        hot_buckets[0] = 0;
        hot_buckets[1] = top_bucket;
        for (int i = 2; i < HOT_COUNT; i++) begin
            hot_buckets[i] = $urandom_range(0, BUCKETS - 1);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
                add_request(OP_LOOKUP, k, 16'($urandom));
            end else if (pick < 45) begin
                k = key_in_bucket(hot_buckets[$urandom_range(0, HOT_COUNT - 1)]);
                add_request(OP_LOOKUP, k, 16'($urandom));
            end else if (pick < 55) begin
                add_request(OP_LOOKUP, KEY_W'($urandom), 16'($urandom));
            end else if (pick < 75) begin
                k = key_in_bucket(hot_buckets[$urandom_range(0, HOT_COUNT - 1)]);
                add_request(OP_INSERT, k, 16'($urandom));
            end else if (pick < 85) begin
                k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
                add_request(OP_INSERT, k, 16'($urandom));
            end else begin
                add_request(OP_INSERT, KEY_W'($urandom), 16'($urandom));
            end
        end

        total_items = pending_requests.size();

        while (accepted_count < total_items || expected_replies.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_replies.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
